/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl modules
// each macro expects clk_i and rst_ni to exist in the module that uses it
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/csp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types and constants of the cpu affinity spec parser.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int unsigned MASK_BITS_DEF = 64;
  localparam int unsigned CH_W          = 8;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned CPU_MASK_W    = 64;
  localparam int unsigned IN_DATA_W     = 8;
  // status and mask packed, padded to whole bytes
  localparam int unsigned OUT_DATA_W    = ((STATUS_W + CPU_MASK_W + 7) / 8) * 8;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY_HEX = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_HEX   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_SYNTAX    = 2'd3;

  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_X     = 8'h78;
  localparam logic [CH_W-1:0] CH_COMMA = 8'h2c;
  localparam logic [CH_W-1:0] CH_DASH  = 8'h2d;
  localparam logic [CH_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CH_W-1:0] CH_LC_F  = 8'h66;
  localparam logic [CH_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [CH_W-1:0] CH_UC_F  = 8'h46;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            is_end;
    logic            new_job;
  } csp_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [CPU_MASK_W-1:0] cpu_mask;
  } csp_result_t;

endpackage

/* rtl/csp_range_mask.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_range_mask
// Parallel comparators that set every cpu bit between lo and hi inclusive.
// ----------------------------------------------------------------------------
module csp_range_mask #(
  parameter int unsigned MASK_BITS = csp_pkg::MASK_BITS_DEF
) (
  input  logic [csp_pkg::CH_W-1:0] lo_i,
  input  logic [csp_pkg::CH_W-1:0] hi_i,
  output logic [MASK_BITS-1:0]     mask_o
);

  for (genvar i = 0; i < MASK_BITS; i++) begin : g_bit
    localparam logic [csp_pkg::CH_W-1:0] Idx = csp_pkg::CH_W'(i);
    // an inverted range leaves every bit clear
    assign mask_o[i] = (lo_i <= Idx) && (Idx <= hi_i);
  end

endmodule

/* rtl/csp_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_core
// Per-character parse state, hex and list decoding and the job mask.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csp_core #(
  parameter int unsigned MASK_BITS = csp_pkg::MASK_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  csp_pkg::csp_item_t   item_i,
  output logic                 res_valid_o,
  output csp_pkg::csp_result_t res_o
);

  typedef enum logic [2:0] {
    PH_START,
    PH_ZERO,
    PH_LIST,
    PH_HEX,
    PH_LERR,
    PH_HERR
  } phase_e;

  phase_e                      phase_q, phase_d;
  logic [MASK_BITS-1:0]        hex_q, hex_d;
  logic [csp_pkg::CH_W-1:0]    number_q, number_d;
  logic [csp_pkg::CH_W-1:0]    range_low_q, range_low_d;
  logic                        range_open_q, range_open_d;
  logic                        seen_q, seen_d;
  logic                        need_q, need_d;
  logic                        prev_q, prev_d;
  logic [MASK_BITS-1:0]        spec_q, spec_d;
  logic [MASK_BITS-1:0]        job_q, job_d;

  logic                        is_digit;
  logic [csp_pkg::CH_W-1:0]    number_dec;
  logic                        close_err;
  logic [csp_pkg::CH_W-1:0]    range_lo;
  logic [MASK_BITS-1:0]        range_bits;
  logic                        hex_ok;
  logic [3:0]                  hex_nib;
  logic [MASK_BITS-1:0]        job_base;
  logic                        end_err;

  assign is_digit = (item_i.ch >= csp_pkg::CH_ZERO) && (item_i.ch <= csp_pkg::CH_NINE);

  // number * 10 + digit, wrapping at 8 bits
  assign number_dec = {number_q[4:0], 3'b000} + {number_q[6:0], 1'b0}
                    + {4'b0000, item_i.ch[3:0]};

  assign close_err = range_open_q && (number_q <= range_low_q);
  assign range_lo  = range_open_q ? range_low_q : number_q;

  csp_range_mask #(
    .MASK_BITS(MASK_BITS)
  ) u_range (
    .lo_i  (range_lo),
    .hi_i  (number_q),
    .mask_o(range_bits)
  );

  always_comb begin
    hex_ok  = 1'b1;
    hex_nib = item_i.ch[3:0];
    if (!is_digit) begin
      if ((item_i.ch >= csp_pkg::CH_LC_A && item_i.ch <= csp_pkg::CH_LC_F) ||
          (item_i.ch >= csp_pkg::CH_UC_A && item_i.ch <= csp_pkg::CH_UC_F)) begin
        // letters a..f have low nibble 1..6
        hex_nib = item_i.ch[3:0] + 4'd9;
      end else begin
        hex_ok  = 1'b0;
        hex_nib = 4'd0;
      end
    end
  end

  assign job_base = item_i.new_job ? '0 : job_q;
  assign end_err  = (phase_q == PH_LERR) || need_q || (prev_q && close_err);

  always_comb begin
    phase_d      = phase_q;
    hex_d        = hex_q;
    number_d     = number_q;
    range_low_d  = range_low_q;
    range_open_d = range_open_q;
    seen_d       = seen_q;
    need_d       = need_q;
    prev_d       = prev_q;
    spec_d       = spec_q;
    job_d        = job_q;
    res_valid_o  = 1'b0;
    res_o.status = csp_pkg::STATUS_OK;
    if (item_valid_i) begin
      job_d = job_base;
      if (!item_i.is_end) begin
        case (phase_q)
          PH_START, PH_ZERO, PH_LIST: begin
            if (phase_q == PH_ZERO && item_i.ch == csp_pkg::CH_X) begin
              phase_d  = PH_HEX;
              number_d = '0;
              seen_d   = 1'b0;
              prev_d   = 1'b0;
            end else begin
              if (phase_q == PH_START) begin
                phase_d = (item_i.ch == csp_pkg::CH_ZERO) ? PH_ZERO : PH_LIST;
              end else begin
                phase_d = PH_LIST;
              end
              if (is_digit) begin
                number_d = number_dec;
                seen_d   = 1'b1;
                prev_d   = 1'b1;
                need_d   = 1'b0;
              end else if (need_q || !seen_q) begin
                phase_d = PH_LERR;
              end else if (item_i.ch == csp_pkg::CH_COMMA) begin
                if (prev_q && close_err) begin
                  phase_d = PH_LERR;
                end else begin
                  if (prev_q) begin
                    spec_d       = spec_q | range_bits;
                    range_open_d = 1'b0;
                    number_d     = '0;
                  end
                  need_d = 1'b1;
                  prev_d = 1'b0;
                end
              end else if (item_i.ch == csp_pkg::CH_DASH) begin
                if (range_open_q) begin
                  phase_d = PH_LERR;
                end else begin
                  range_low_d  = number_q;
                  range_open_d = 1'b1;
                  number_d     = '0;
                  need_d       = 1'b1;
                  prev_d       = 1'b0;
                end
              end else begin
                phase_d = PH_LERR;
              end
            end
          end
          PH_HEX: begin
            if (hex_ok) begin
              hex_d  = {hex_q[MASK_BITS-5:0], hex_nib};
              seen_d = 1'b1;
            end else begin
              phase_d = PH_HERR;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end else begin
        res_valid_o = 1'b1;
        case (phase_q)
          PH_HEX: begin
            if (seen_q) begin
              job_d = job_base | hex_q;
            end else begin
              res_o.status = csp_pkg::STATUS_EMPTY_HEX;
            end
          end
          PH_HERR: begin
            res_o.status = csp_pkg::STATUS_BAD_HEX;
          end
          default: begin
            if (end_err) begin
              res_o.status = csp_pkg::STATUS_SYNTAX;
            end else begin
              job_d = job_base | spec_q | (prev_q ? range_bits : '0);
            end
          end
        endcase
        phase_d      = PH_START;
        hex_d        = '0;
        number_d     = '0;
        range_low_d  = '0;
        range_open_d = 1'b0;
        seen_d       = 1'b0;
        need_d       = 1'b0;
        prev_d       = 1'b0;
        spec_d       = '0;
      end
    end
    res_o.cpu_mask = csp_pkg::CPU_MASK_W'(job_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_START;
      hex_q        <= '0;
      number_q     <= '0;
      range_low_q  <= '0;
      range_open_q <= 1'b0;
      seen_q       <= 1'b0;
      need_q       <= 1'b0;
      prev_q       <= 1'b0;
      spec_q       <= '0;
      job_q        <= '0;
    end else begin
      phase_q      <= phase_d;
      hex_q        <= hex_d;
      number_q     <= number_d;
      range_low_q  <= range_low_d;
      range_open_q <= range_open_d;
      seen_q       <= seen_d;
      need_q       <= need_d;
      prev_q       <= prev_d;
      spec_q       <= spec_d;
      job_q        <= job_d;
    end
  end

  `ASSERT_NEXT(a_job_hold, !item_valid_i, $stable(job_q), "job mask changed with no item")
  `ASSERT_NEXT(a_end_clears, item_valid_i && item_i.is_end,
               phase_q == PH_START && spec_q == '0, "string state not cleared after end")
  `ASSERT_IMPL(a_hex_idle, phase_q != PH_HEX && phase_q != PH_HERR, hex_q == '0,
               "hex accumulator set outside hex form")
  `ASSERT_IMPL(a_need_after_digit, need_q, seen_q && !prev_q,
               "separator pending without a preceding number")

endmodule

/* rtl/cpu_affinity_spec_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_affinity_spec_parser
// Parses cpu affinity specs (hex masks or decimal cpu lists) one character
// per transaction and ORs each valid spec into an accumulated job mask.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                         tlast    tuser
//  s_axis    in   ch[7:0]                       is_end   new_job
//  m_axis    out  status[1:0], cpu_mask[65:2]   -        -
//
//  one character per cycle sustained while no end marker waits on a stalled result;
//  the parse state updates in one pass; an accepted end marker's result passes
//  the input register, then the result register, before it leaves
//  reset clears the parse state, the job mask and both valid flags
//  a stalled result holds only an end marker in the input register;
//  other characters keep flowing
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpu_affinity_spec_parser #(
  parameter int unsigned MASK_BITS = csp_pkg::MASK_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [csp_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // ch[7:0]
  input  logic                           s_axis_tlast,   // is_end
  input  logic                           s_axis_tuser,   // new_job
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [csp_pkg::OUT_DATA_W-1:0] m_axis_tdata    // status[1:0], cpu_mask[65:2]
);

  logic                 in_valid_q;
  csp_pkg::csp_item_t   in_item_q;
  logic                 advance;
  logic                 res_valid;
  csp_pkg::csp_result_t res;
  logic                 out_valid_q;
  csp_pkg::csp_result_t out_q;

  // an end marker needs room in the result register
  assign advance = in_valid_q && (!in_item_q.is_end || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.ch      <= s_axis_tdata[csp_pkg::CH_W-1:0];
      in_item_q.is_end  <= s_axis_tlast;
      in_item_q.new_job <= s_axis_tuser;
    end
  end

  csp_core #(
    .MASK_BITS(MASK_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(advance),
    .item_i      (in_item_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(csp_pkg::OUT_DATA_W - csp_pkg::STATUS_W - csp_pkg::CPU_MASK_W){1'b0}},
                          out_q.cpu_mask, out_q.status};

  `ASSERT_IMPL(a_result_from_end, $rose(out_valid_q), $past(in_item_q.is_end && advance),
               "result produced without an end marker")
  `ASSERT_IMPL(a_no_overwrite, out_valid_q && !m_axis_tready, !(advance && res_valid),
               "pending result overwritten")

endmodule

/* tb/cpu_affinity_spec_parser_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_affinity_spec_parser_tb
// Streams cpu affinity specs into the parser one character per transaction.
// A table of directed specs comes first, then random specs. The random specs
// are mostly well-formed lists and hex masks, and the rest are corrupted
// specs and noise. A parser model in the bench predicts the status and job
// mask for each end marker, save where a directed spec has typed ones. Each
// result is compared in order against the oldest expected one.
// ----------------------------------------------------------------------------
module cpu_affinity_spec_parser_tb;

  localparam int unsigned CPU_LIMIT    = csp_pkg::MASK_BITS_DEF;
  localparam int          RANDOM_ITEMS = 1900;
  localparam int          DIR_ROWS     = 22;

  typedef enum logic [2:0] {
    PH_START, PH_LEAD_ZERO, PH_LIST, PH_HEX, PH_LIST_ERR, PH_HEX_ERR
  } parse_phase_e;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [csp_pkg::IN_DATA_W-1:0]  s_axis_tdata;   // ch[7:0]
  logic                           s_axis_tlast;   // is_end
  logic                           s_axis_tuser;   // new_job
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [csp_pkg::OUT_DATA_W-1:0] m_axis_tdata;   // status[1:0], cpu_mask[65:2]

  cpu_affinity_spec_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // parser model state
  parse_phase_e          parse_phase;
  logic [63:0]           hex_accum;
  logic [7:0]            cur_number;
  logic [7:0]            range_low;
  logic                  range_open;
  logic                  seen_digit;
  logic                  need_digit;
  logic                  prev_digit;
  logic [CPU_LIMIT-1:0]  spec_cpus;
  logic [CPU_LIMIT-1:0]  job_cpus;

  csp_pkg::csp_result_t awaited_results[$];
  logic [7:0]           spec_chars[$];

  int send_idle_pct;
  int recv_stall_pct;
  int items_sent;
  int specs_sent;
  int results_seen;
  int ok_seen;
  int error_seen;
  int errors;

  // directed specs; typed expectations only where they are obvious
  string       dir_spec   [DIR_ROWS] = '{
    "", "0", "63", "64,200", "0x", "0xfF", "0x123456789abcdef01", "0xG1",
    "1,3-5", "3-3", "-1", ",1", "1,", "1-", "1-2-3", "1,,2", "1 2", "0X1",
    "256", "07", "5-300", "60-70"};
  bit          dir_new_job[DIR_ROWS] = '{
    1, 0, 0, 1, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
  bit          dir_typed  [DIR_ROWS] = '{
    1, 1, 1, 1, 1, 0, 0, 1, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0};
  logic [1:0]  dir_status [DIR_ROWS] = '{
    csp_pkg::STATUS_OK, csp_pkg::STATUS_OK, csp_pkg::STATUS_OK, csp_pkg::STATUS_OK,
    csp_pkg::STATUS_EMPTY_HEX, csp_pkg::STATUS_OK, csp_pkg::STATUS_OK,
    csp_pkg::STATUS_BAD_HEX, csp_pkg::STATUS_OK, csp_pkg::STATUS_SYNTAX,
    csp_pkg::STATUS_SYNTAX, csp_pkg::STATUS_SYNTAX, csp_pkg::STATUS_SYNTAX,
    csp_pkg::STATUS_SYNTAX, csp_pkg::STATUS_SYNTAX, csp_pkg::STATUS_SYNTAX,
    csp_pkg::STATUS_SYNTAX, csp_pkg::STATUS_SYNTAX, csp_pkg::STATUS_OK,
    csp_pkg::STATUS_OK, csp_pkg::STATUS_OK, csp_pkg::STATUS_OK};
  logic [63:0] dir_mask   [DIR_ROWS] = '{
    64'h0, 64'h1, 64'h8000_0000_0000_0001, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0,
    64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0,
    64'h0, 64'h0, 64'h0, 64'h0};

  function automatic void clear_spec_state();
    parse_phase = PH_START;
    hex_accum   = '0;
    cur_number  = '0;
    range_low   = '0;
    range_open  = 1'b0;
    seen_digit  = 1'b0;
    need_digit  = 1'b0;
    prev_digit  = 1'b0;
    spec_cpus   = '0;
  endfunction

  function automatic void add_cpus(input int unsigned lo, input int unsigned hi);
    int unsigned top;
    if (lo >= CPU_LIMIT || hi < lo) return;
    top = (hi >= CPU_LIMIT) ? CPU_LIMIT - 1 : hi;
    for (int unsigned i = lo; i <= top; i++) spec_cpus[i] = 1'b1;
  endfunction

  function automatic void close_number();
    if (range_open) begin
      range_open = 1'b0;
      if (cur_number <= range_low) parse_phase = PH_LIST_ERR;
      else add_cpus(range_low, cur_number);
    end else begin
      add_cpus(cur_number, cur_number);
    end
    cur_number = '0;
    prev_digit = 1'b0;
  endfunction

  function automatic void list_char(input logic [7:0] c);
    if (c >= csp_pkg::CH_ZERO && c <= csp_pkg::CH_NINE) begin
      cur_number = cur_number * 8'd10 + (c - csp_pkg::CH_ZERO);
      seen_digit = 1'b1;
      prev_digit = 1'b1;
      need_digit = 1'b0;
      return;
    end
    if (need_digit || !seen_digit) begin
      parse_phase = PH_LIST_ERR;
      return;
    end
    if (c == csp_pkg::CH_COMMA) begin
      if (prev_digit) close_number();
      if (parse_phase == PH_LIST_ERR) return;
      need_digit = 1'b1;
      prev_digit = 1'b0;
    end else if (c == csp_pkg::CH_DASH) begin
      if (range_open) begin
        parse_phase = PH_LIST_ERR;
        return;
      end
      range_low  = cur_number;
      range_open = 1'b1;
      cur_number = '0;
      need_digit = 1'b1;
      prev_digit = 1'b0;
    end else begin
      parse_phase = PH_LIST_ERR;
    end
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= csp_pkg::CH_ZERO && c <= csp_pkg::CH_NINE)
      return {1'b1, 4'(c - csp_pkg::CH_ZERO)};
    if (c >= csp_pkg::CH_LC_A && c <= csp_pkg::CH_LC_F)
      return {1'b1, 4'(c - csp_pkg::CH_LC_A + 8'd10)};
    if (c >= csp_pkg::CH_UC_A && c <= csp_pkg::CH_UC_F)
      return {1'b1, 4'(c - csp_pkg::CH_UC_A + 8'd10)};
    return 5'd0;
  endfunction

  function automatic void spec_parse_step(input logic [7:0] c, input logic last,
                                          input logic nj, output logic got,
                                          output csp_pkg::csp_result_t res);
    logic [4:0] nib;
    logic [1:0] st;
    got = 1'b0;
    res = '0;
    st  = csp_pkg::STATUS_OK;
    if (nj) job_cpus = '0;
    if (!last) begin
      case (parse_phase)
        PH_START: begin
          list_char(c);
          if (parse_phase == PH_START)
            parse_phase = (c == csp_pkg::CH_ZERO) ? PH_LEAD_ZERO : PH_LIST;
        end
        PH_LEAD_ZERO: begin
          if (c == csp_pkg::CH_X) begin
            parse_phase = PH_HEX;
            cur_number  = '0;
            seen_digit  = 1'b0;
            prev_digit  = 1'b0;
          end else begin
            parse_phase = PH_LIST;
            list_char(c);
          end
        end
        PH_LIST: list_char(c);
        PH_HEX: begin
          nib = hex_nibble(c);
          if (!nib[4]) parse_phase = PH_HEX_ERR;
          else begin
            hex_accum  = {hex_accum[59:0], nib[3:0]};
            seen_digit = 1'b1;
          end
        end
        default: ;
      endcase
      return;
    end
    if (parse_phase == PH_HEX) begin
      if (!seen_digit) st = csp_pkg::STATUS_EMPTY_HEX;
      else job_cpus |= hex_accum[CPU_LIMIT-1:0];
    end else if (parse_phase == PH_HEX_ERR) begin
      st = csp_pkg::STATUS_BAD_HEX;
    end else begin
      if (parse_phase != PH_LIST_ERR) begin
        if (need_digit) parse_phase = PH_LIST_ERR;
        else if (prev_digit) close_number();
      end
      if (parse_phase == PH_LIST_ERR) st = csp_pkg::STATUS_SYNTAX;
      else job_cpus |= spec_cpus;
    end
    got          = 1'b1;
    res.status   = st;
    res.cpu_mask = 64'(job_cpus);
    clear_spec_state();
  endfunction

  // starts and ends at a falling edge
  task automatic send_item(input logic [7:0] ch, input logic last, input logic nj,
                           input logic typed, input logic [1:0] t_status,
                           input logic [63:0] t_mask);
    logic                 got;
    csp_pkg::csp_result_t res;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = ch;
    s_axis_tlast  = last;
    s_axis_tuser  = nj;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    spec_parse_step(ch, last, nj, got, res);
    if (got) begin
      if (typed) begin
        res.status   = t_status;
        res.cpu_mask = t_mask;
      end
      awaited_results.push_back(res);
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_spec(input logic nj, input logic scatter, input logic typed,
                           input logic [1:0] t_status, input logic [63:0] t_mask);
    int n;
    n = spec_chars.size();
    for (int i = 0; i < n; i++)
      send_item(spec_chars[i], 1'b0,
                (i == 0 && nj) || (scatter && $urandom_range(0, 29) == 0),
                1'b0, csp_pkg::STATUS_OK, '0);
    send_item(8'($urandom_range(0, 255)), 1'b1,
              (n == 0 && nj) || (scatter && $urandom_range(0, 29) == 0),
              typed, t_status, t_mask);
    specs_sent++;
  endtask

  task automatic push_text(input string t);
    for (int i = 0; i < t.len(); i++) spec_chars.push_back(t[i]);
  endtask

  function automatic int rand_cpu();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 299) : $urandom_range(0, 70);
  endfunction

  task automatic push_cpu_list();
    int n;
    int lo;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      if (i != 0) spec_chars.push_back(csp_pkg::CH_COMMA);
      lo = rand_cpu();
      if ($urandom_range(0, 2) == 0)
        push_text($sformatf("%0d-%0d", lo, lo + $urandom_range(1, 20)));
      else
        push_text($sformatf("%0d", lo));
    end
  endtask

  task automatic push_hex_mask();
    int  v;
    push_text("0x");
    repeat ($urandom_range(0, 18)) begin
      v = $urandom_range(0, 15);
      if (v < 10) spec_chars.push_back(csp_pkg::CH_ZERO + 8'(v));
      else spec_chars.push_back(($urandom_range(0, 1) ? csp_pkg::CH_UC_A : csp_pkg::CH_LC_A)
                                + 8'(v - 10));
    end
  endtask

  task automatic build_random_spec();
    int pick;
    int lo;
    spec_chars.delete();
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      push_cpu_list();
    end else if (pick < 60) begin
      push_hex_mask();
    end else if (pick < 82) begin
      push_cpu_list();
      case ($urandom_range(0, 4))
        0: spec_chars.push_front($urandom_range(0, 1) ? csp_pkg::CH_COMMA : csp_pkg::CH_DASH);
        1: spec_chars.push_back($urandom_range(0, 1) ? csp_pkg::CH_COMMA : csp_pkg::CH_DASH);
        2: spec_chars[$urandom_range(0, spec_chars.size() - 1)] = 8'($urandom_range(0, 255));
        3: push_text(",,");
        default: begin
          // range whose end does not exceed its start
          lo = $urandom_range(0, 70);
          push_text($sformatf(",%0d-%0d", lo, lo - $urandom_range(0, lo)));
        end
      endcase
    end else if (pick < 94) begin
      push_hex_mask();
      if (spec_chars.size() > 2)
        spec_chars[$urandom_range(2, spec_chars.size() - 1)] = 8'($urandom_range(0, 255));
      else
        spec_chars.push_back(8'($urandom_range(csp_pkg::CH_LC_F + 1, 255)));
    end else begin
      repeat ($urandom_range(0, 5)) spec_chars.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  csp_pkg::csp_result_t want;
  logic [1:0]           got_status;
  logic [63:0]          got_mask;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_status = m_axis_tdata[1:0];
      got_mask   = m_axis_tdata[65:2];
      results_seen++;
      if (got_status == csp_pkg::STATUS_OK) ok_seen++;
      else error_seen++;
      if (awaited_results.size() == 0) begin
        $display("%0t ns: result with none expected, got status %0d mask %h",
                 $time, got_status, got_mask);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (got_status != want.status) begin
          $display("%0t ns: status mismatch, expected %0d, got %0d",
                   $time, want.status, got_status);
          errors++;
        end
        if (got_mask != want.cpu_mask) begin
          $display("%0t ns: cpu mask mismatch, expected %h, got %h",
                   $time, want.cpu_mask, got_mask);
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", awaited_results.size());
    $display("cpu_affinity_spec_parser_tb: FAIL");
    $finish;
  end

  initial begin
    int target;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tlast   = 1'b0;
    s_axis_tuser   = 1'b0;
    send_idle_pct  = 14;
    recv_stall_pct = 62;
    items_sent     = 0;
    specs_sent     = 0;
    results_seen   = 0;
    ok_seen        = 0;
    error_seen     = 0;
    errors         = 0;
    job_cpus       = '0;
    clear_spec_state();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      spec_chars.delete();
      push_text(dir_spec[r]);
      send_spec(dir_new_job[r], 1'b0, dir_typed[r], dir_status[r], dir_mask[r]);
    end

    // receiver stalls first, then the sender idles, then full rate
    for (int p = 0; p < 3; p++) begin
      send_idle_pct  = (p == 0) ? 14 : (p == 1) ? 62 : 0;
      recv_stall_pct = (p == 0) ? 62 : (p == 1) ? 14 : 0;
      target = items_sent + RANDOM_ITEMS / 3;
      while (items_sent < target) begin
        build_random_spec();
        send_spec($urandom_range(0, 4) == 0, 1'b1, 1'b0, csp_pkg::STATUS_OK, '0);
      end
    end
    s_axis_tvalid = 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("ran %0d specs as %0d characters; %0d results checked, %0d ok, %0d with errors",
             specs_sent, items_sent, results_seen, ok_seen, error_seen);
    if (errors == 0) begin
      $display("cpu_affinity_spec_parser_tb: PASS");
    end else begin
      $display("cpu_affinity_spec_parser_tb: FAIL");
    end
    $finish;
  end

endmodule
